FILE: rtl/core/glpm_pkg.sv
// ============================================================================
// glpm_pkg
// Shared types, widths and constants of the Gaussian location prior map core.
// ============================================================================
package glpm_pkg;

    // Field and register widths
    localparam int COORD_BITS = 12;
    localparam int DIM_BITS   = 13;
    localparam int MODE_BITS  = 4;
    localparam int ADDR_BITS  = 5;
    localparam int DATA_BITS  = 32;

    // Internal datapath widths
    localparam int SQ_BITS = 2 * DIM_BITS;        // squared distance or size
    localparam int P_BITS  = SQ_BITS + 8;         // 200 times a square
    localparam int T_BITS  = 20;                  // exponent bits, Q4.16
    localparam int T_FRAC  = 16;                  // fraction bits of the exponent
    localparam int R_BITS  = SQ_BITS + T_BITS;    // divider remainder

    // Algorithm constants
    localparam int GAIN    = 200;
    localparam int TOP_ROW = 20;

    // Parameter defaults
    localparam int MAX_DIM_DEF     = 4096;
    localparam int WEIGHT_BITS_DEF = 16;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_CENTER        = 4'd0,
        MODE_LEFT_CENTER   = 4'd1,
        MODE_LEFT          = 4'd2,
        MODE_RIGHT_CENTER  = 4'd3,
        MODE_RIGHT         = 4'd4,
        MODE_TOP_CENTER    = 4'd5,
        MODE_TOP           = 4'd6,
        MODE_BOTTOM_CENTER = 4'd7,
        MODE_BOTTOM        = 4'd8,
        MODE_CUSTOM        = 4'd9
    } mode_t;

    typedef enum logic [2:0] {
        REG_MODE   = 3'd0,
        REG_WIDTH  = 3'd1,
        REG_HEIGHT = 3'd2,
        REG_CX     = 3'd3,
        REG_CY     = 3'd4
    } reg_idx_t;

    // Factor for exponent bit idx: exp(-2^(idx-16)) in Q0.32, obtained by
    // repeated rounded squaring of exp(-2^-16).
    function automatic logic [31:0] glpm_exp_factor(input int idx);
        logic [63:0] f;
        f = 64'h0000_0000_FFFF_0000;
        for (int n = 0; n < idx; n++)
        begin
            f = (f * f + 64'h0000_0000_8000_0000) >> 32;
        end
        return f[31:0];
    endfunction

endpackage

FILE: rtl/core/gaussian_location_prior_map_core.sv
// ============================================================================
// gaussian_location_prior_map_core
// Location prior weight exp(-200*((dx/W)^2 + (dy/H)^2)) for one pixel per
// transaction, with the centre chosen by the location mode register, which can also zero one axis.
// ============================================================================
//
//  Channel | Signals                                   | Direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_stall, pixel_row, pixel_col  | into core
//  out     | out_valid, out_stall, weight, status      | out of core
//  cfg     | psel, penable, pwrite, paddr, pwdata,     | APB slave
//          | prdata, pready                            |
//
// One pixel is taken every cycle while the output does not stall. The
// pipeline holds one centre stage, a squaring stage, a scaling stage, a
// saturation check, 20 restoring divider stages (one quotient bit each),
// one summing stage, 20 multiplier stages (one exponent bit each) and the
// output register.
// Reset clears the configuration registers, the squared frame sizes and all
// valid bits; the squared frame sizes follow a register write in the next cycle.
// A stall on the output with a result waiting freezes the whole pipeline and
// stalls the input.
module gaussian_location_prior_map_core
    import glpm_pkg::*;
#(
    parameter int MAX_DIM     = MAX_DIM_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [COORD_BITS-1:0]  pixel_row,
    input  logic [COORD_BITS-1:0]  pixel_col,

    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [WEIGHT_BITS-1:0] weight,
    output logic                   status,

    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_BITS-1:0]   paddr,
    input  logic [DATA_BITS-1:0]   pwdata,
    output logic [DATA_BITS-1:0]   prdata,
    output logic                   pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [MODE_BITS-1:0]  location_mode_reg;
    logic [DIM_BITS-1:0]   frame_width_reg;
    logic [DIM_BITS-1:0]   frame_height_reg;
    logic [COORD_BITS-1:0] custom_center_x_reg;
    logic [COORD_BITS-1:0] custom_center_y_reg;
    logic                  cfg_write;
    reg_idx_t              cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = reg_idx_t'(paddr[ADDR_BITS-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            location_mode_reg   <= '0;
            frame_width_reg     <= '0;
            frame_height_reg    <= '0;
            custom_center_x_reg <= '0;
            custom_center_y_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_MODE:   location_mode_reg   <= pwdata[MODE_BITS-1:0];
                REG_WIDTH:  frame_width_reg     <= pwdata[DIM_BITS-1:0];
                REG_HEIGHT: frame_height_reg    <= pwdata[DIM_BITS-1:0];
                REG_CX:     custom_center_x_reg <= pwdata[COORD_BITS-1:0];
                REG_CY:     custom_center_y_reg <= pwdata[COORD_BITS-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_MODE:   prdata = DATA_BITS'(location_mode_reg);
            REG_WIDTH:  prdata = DATA_BITS'(frame_width_reg);
            REG_HEIGHT: prdata = DATA_BITS'(frame_height_reg);
            REG_CX:     prdata = DATA_BITS'(custom_center_x_reg);
            REG_CY:     prdata = DATA_BITS'(custom_center_y_reg);
            default:    prdata = '0;
        endcase
    end

    // Clamped frame size and its square, which serves as the divisor.
    logic [DIM_BITS-1:0] w_clamp;
    logic [DIM_BITS-1:0] h_clamp;
    logic [SQ_BITS-1:0]  w_sq_reg;
    logic [SQ_BITS-1:0]  h_sq_reg;

    assign w_clamp = (32'(frame_width_reg) > 32'(MAX_DIM)) ?
                     DIM_BITS'(MAX_DIM) : frame_width_reg;
    assign h_clamp = (32'(frame_height_reg) > 32'(MAX_DIM)) ?
                     DIM_BITS'(MAX_DIM) : frame_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_sq_reg <= '0;
            h_sq_reg <= '0;
        end
        else
        begin
            w_sq_reg <= w_clamp * w_clamp;
            h_sq_reg <= h_clamp * h_clamp;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    logic adv;
    logic out_valid_reg;

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    // ------------------------------------------------------------------
    // Stage A: centre selection and absolute distances
    // ------------------------------------------------------------------
    logic                       a_valid_reg;
    logic                       a_err_reg;
    logic [DIM_BITS-1:0]        a_mx_reg;
    logic [DIM_BITS-1:0]        a_my_reg;
    logic                       a_err_next;
    logic [DIM_BITS-1:0]        a_mx_next;
    logic [DIM_BITS-1:0]        a_my_next;
    logic [DIM_BITS-1:0]        cx;
    logic [DIM_BITS-1:0]        cy;
    logic                       use_x;
    logic                       use_y;
    logic [DIM_BITS+2:0]        w_times7;
    logic [DIM_BITS+2:0]        h_times7;
    logic signed [DIM_BITS:0]   dx;
    logic signed [DIM_BITS:0]   dy;
    logic signed [DIM_BITS:0]   dx_neg;
    logic signed [DIM_BITS:0]   dy_neg;

    always_comb
    begin
        w_times7 = ({3'b000, w_clamp} << 3) - {3'b000, w_clamp};
        h_times7 = ({3'b000, h_clamp} << 3) - {3'b000, h_clamp};
        cx       = w_clamp >> 1;
        cy       = h_clamp >> 1;
        use_x    = 1'b1;
        use_y    = 1'b1;
        unique case (mode_t'(location_mode_reg))
            MODE_LEFT_CENTER:   cx = w_clamp >> 3;
            MODE_LEFT:
            begin
                cx    = w_clamp >> 3;
                use_y = 1'b0;
            end
            MODE_RIGHT_CENTER:  cx = w_times7[DIM_BITS+2:3];
            MODE_RIGHT:
            begin
                cx    = w_times7[DIM_BITS+2:3];
                use_y = 1'b0;
            end
            MODE_TOP_CENTER:    cy = DIM_BITS'(TOP_ROW);
            MODE_TOP:
            begin
                cy    = DIM_BITS'(TOP_ROW);
                use_x = 1'b0;
            end
            MODE_BOTTOM_CENTER: cy = h_times7[DIM_BITS+2:3];
            MODE_BOTTOM:
            begin
                cy    = h_times7[DIM_BITS+2:3];
                use_x = 1'b0;
            end
            MODE_CUSTOM:
            begin
                cx = {1'b0, custom_center_x_reg};
                cy = {1'b0, custom_center_y_reg};
            end
            default:            ;
        endcase

        dx     = $signed({2'b00, pixel_col}) - $signed({1'b0, cx});
        dy     = $signed({2'b00, pixel_row}) - $signed({1'b0, cy});
        dx_neg = -dx;
        dy_neg = -dy;

        // A disabled axis gets zero distance, so its term comes out zero.
        a_mx_next  = !use_x ? '0 : (dx[DIM_BITS] ? dx_neg[DIM_BITS-1:0] : dx[DIM_BITS-1:0]);
        a_my_next  = !use_y ? '0 : (dy[DIM_BITS] ? dy_neg[DIM_BITS-1:0] : dy[DIM_BITS-1:0]);
        a_err_next = (w_clamp == '0) || (h_clamp == '0);
    end

    // ------------------------------------------------------------------
    // Stages B to D: squaring, scaling by 200, saturation check
    // ------------------------------------------------------------------
    logic               b_valid_reg;
    logic               b_err_reg;
    logic [SQ_BITS-1:0] b_sqx_reg;
    logic [SQ_BITS-1:0] b_sqy_reg;

    logic               c_valid_reg;
    logic               c_err_reg;
    logic [P_BITS-1:0]  c_px_reg;
    logic [P_BITS-1:0]  c_py_reg;

    logic               d_valid_reg;
    logic               d_err_reg;
    logic               d_satx_reg;
    logic               d_saty_reg;
    logic [R_BITS-1:0]  d_rx_reg;
    logic [R_BITS-1:0]  d_ry_reg;

    logic [P_BITS+T_FRAC-1:0] num_x;
    logic [P_BITS+T_FRAC-1:0] num_y;
    logic                     d_satx_next;
    logic                     d_saty_next;

    // The quotient only matters below 2^20: 200*d^2*2^16 >= s^2*2^20 is
    // the same as 200*d^2 >= 16*s^2.
    always_comb
    begin
        num_x       = {c_px_reg, {T_FRAC{1'b0}}};
        num_y       = {c_py_reg, {T_FRAC{1'b0}}};
        d_satx_next = c_px_reg >= P_BITS'({w_sq_reg, 4'b0000});
        d_saty_next = c_py_reg >= P_BITS'({h_sq_reg, 4'b0000});
    end

    // ------------------------------------------------------------------
    // Divider stages: one quotient bit per stage, most significant first
    // ------------------------------------------------------------------
    logic              dv_valid_reg [T_BITS];
    logic              dv_err_reg   [T_BITS];
    logic              dv_satx_reg  [T_BITS];
    logic              dv_saty_reg  [T_BITS];
    logic [R_BITS-1:0] dv_rx_reg    [T_BITS];
    logic [R_BITS-1:0] dv_ry_reg    [T_BITS];
    logic [T_BITS-1:0] dv_qx_reg    [T_BITS];
    logic [T_BITS-1:0] dv_qy_reg    [T_BITS];

    // ------------------------------------------------------------------
    // Exponent sum stage and exponential stages
    // ------------------------------------------------------------------
    logic              s_valid_reg;
    logic              s_err_reg;
    logic              s_zero_reg;
    logic [T_BITS-1:0] s_t_reg;
    logic [T_BITS:0]   tx_full;
    logic [T_BITS:0]   ty_full;
    logic [T_BITS+1:0] t_sum;

    always_comb
    begin
        tx_full = dv_satx_reg[T_BITS-1] ? (T_BITS+1)'(1) << T_BITS :
                  {1'b0, dv_qx_reg[T_BITS-1]};
        ty_full = dv_saty_reg[T_BITS-1] ? (T_BITS+1)'(1) << T_BITS :
                  {1'b0, dv_qy_reg[T_BITS-1]};
        t_sum   = {1'b0, tx_full} + {1'b0, ty_full};
    end

    logic              ex_valid_reg [T_BITS];
    logic              ex_err_reg   [T_BITS];
    logic              ex_zero_reg  [T_BITS];
    logic              ex_one_reg   [T_BITS];
    logic [T_BITS-1:0] ex_t_reg     [T_BITS];
    logic [31:0]       ex_r_reg     [T_BITS];

    // ------------------------------------------------------------------
    // Valid bits
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            s_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg   <= in_valid;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            d_valid_reg   <= c_valid_reg;
            s_valid_reg   <= dv_valid_reg[T_BITS-1];
            out_valid_reg <= ex_valid_reg[T_BITS-1];
        end
    end

    // ------------------------------------------------------------------
    // Front stage payload
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_err_reg  <= a_err_next;
            a_mx_reg   <= a_mx_next;
            a_my_reg   <= a_my_next;

            b_err_reg  <= a_err_reg;
            b_sqx_reg  <= a_mx_reg * a_mx_reg;
            b_sqy_reg  <= a_my_reg * a_my_reg;

            c_err_reg  <= b_err_reg;
            c_px_reg   <= P_BITS'(b_sqx_reg) * P_BITS'(GAIN);
            c_py_reg   <= P_BITS'(b_sqy_reg) * P_BITS'(GAIN);

            d_err_reg  <= c_err_reg;
            d_satx_reg <= d_satx_next;
            d_saty_reg <= d_saty_next;
            d_rx_reg   <= num_x[R_BITS-1:0];
            d_ry_reg   <= num_y[R_BITS-1:0];

            s_err_reg  <= dv_err_reg[T_BITS-1];
            s_zero_reg <= t_sum[T_BITS+1] | t_sum[T_BITS];
            s_t_reg    <= t_sum[T_BITS-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Divider pipeline
    // ------------------------------------------------------------------
    for (genvar j = 0; j < T_BITS; j++)
    begin : g_div
        localparam int BIT = T_BITS - 1 - j;

        logic              prev_valid;
        logic              prev_err;
        logic              prev_satx;
        logic              prev_saty;
        logic [R_BITS-1:0] prev_rx;
        logic [R_BITS-1:0] prev_ry;
        logic [T_BITS-1:0] prev_qx;
        logic [T_BITS-1:0] prev_qy;
        logic [R_BITS-1:0] trial_x;
        logic [R_BITS-1:0] trial_y;
        logic              ge_x;
        logic              ge_y;
        logic [R_BITS-1:0] rx_next;
        logic [R_BITS-1:0] ry_next;
        logic [T_BITS-1:0] qx_next;
        logic [T_BITS-1:0] qy_next;

        if (j == 0)
        begin : g_first
            assign prev_valid = d_valid_reg;
            assign prev_err   = d_err_reg;
            assign prev_satx  = d_satx_reg;
            assign prev_saty  = d_saty_reg;
            assign prev_rx    = d_rx_reg;
            assign prev_ry    = d_ry_reg;
            assign prev_qx    = '0;
            assign prev_qy    = '0;
        end
        else
        begin : g_next
            assign prev_valid = dv_valid_reg[j-1];
            assign prev_err   = dv_err_reg[j-1];
            assign prev_satx  = dv_satx_reg[j-1];
            assign prev_saty  = dv_saty_reg[j-1];
            assign prev_rx    = dv_rx_reg[j-1];
            assign prev_ry    = dv_ry_reg[j-1];
            assign prev_qx    = dv_qx_reg[j-1];
            assign prev_qy    = dv_qy_reg[j-1];
        end

        always_comb
        begin
            trial_x      = R_BITS'(w_sq_reg) << BIT;
            trial_y      = R_BITS'(h_sq_reg) << BIT;
            ge_x         = prev_rx >= trial_x;
            ge_y         = prev_ry >= trial_y;
            rx_next      = ge_x ? prev_rx - trial_x : prev_rx;
            ry_next      = ge_y ? prev_ry - trial_y : prev_ry;
            qx_next      = prev_qx;
            qy_next      = prev_qy;
            qx_next[BIT] = ge_x;
            qy_next[BIT] = ge_y;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[j] <= 1'b0;
            end
            else if (adv)
            begin
                dv_valid_reg[j] <= prev_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_err_reg[j]  <= prev_err;
                dv_satx_reg[j] <= prev_satx;
                dv_saty_reg[j] <= prev_saty;
                dv_rx_reg[j]   <= rx_next;
                dv_ry_reg[j]   <= ry_next;
                dv_qx_reg[j]   <= qx_next;
                dv_qy_reg[j]   <= qy_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Exponential pipeline: multiply by exp(-2^(i-16)) where bit i is set
    // ------------------------------------------------------------------
    for (genvar i = 0; i < T_BITS; i++)
    begin : g_exp
        localparam logic [31:0] FACTOR = glpm_exp_factor(i);

        logic              prev_valid;
        logic              prev_err;
        logic              prev_zero;
        logic              prev_one;
        logic [T_BITS-1:0] prev_t;
        logic [31:0]       prev_r;
        logic [63:0]       prod;
        logic [31:0]       r_next;
        logic              one_next;

        if (i == 0)
        begin : g_first
            assign prev_valid = s_valid_reg;
            assign prev_err   = s_err_reg;
            assign prev_zero  = s_zero_reg;
            assign prev_one   = 1'b1;
            assign prev_t     = s_t_reg;
            assign prev_r     = '0;
        end
        else
        begin : g_next
            assign prev_valid = ex_valid_reg[i-1];
            assign prev_err   = ex_err_reg[i-1];
            assign prev_zero  = ex_zero_reg[i-1];
            assign prev_one   = ex_one_reg[i-1];
            assign prev_t     = ex_t_reg[i-1];
            assign prev_r     = ex_r_reg[i-1];
        end

        // While the product is still exactly 1.0 it is kept as a flag, and
        // the first factor is taken as it is.
        always_comb
        begin
            prod     = prev_r * FACTOR + 64'h0000_0000_8000_0000;
            r_next   = prev_r;
            one_next = prev_one;
            if (prev_t[i])
            begin
                r_next   = prev_one ? FACTOR : prod[63:32];
                one_next = 1'b0;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ex_valid_reg[i] <= 1'b0;
            end
            else if (adv)
            begin
                ex_valid_reg[i] <= prev_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ex_err_reg[i]  <= prev_err;
                ex_zero_reg[i] <= prev_zero;
                ex_one_reg[i]  <= one_next;
                ex_t_reg[i]    <= prev_t;
                ex_r_reg[i]    <= r_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stage: rounding to WEIGHT_BITS with saturation
    // ------------------------------------------------------------------
    logic [WEIGHT_BITS-1:0] weight_reg;
    logic                   status_reg;
    logic [WEIGHT_BITS-1:0] weight_next;
    logic [32:0]            r_round;
    logic [WEIGHT_BITS:0]   w_full;

    always_comb
    begin
        r_round = {1'b0, ex_r_reg[T_BITS-1]} + (33'd1 << (31 - WEIGHT_BITS));
        w_full  = r_round[32:32-WEIGHT_BITS];
        if (ex_err_reg[T_BITS-1] || ex_zero_reg[T_BITS-1])
        begin
            weight_next = '0;
        end
        else if (ex_one_reg[T_BITS-1] || w_full[WEIGHT_BITS])
        begin
            weight_next = '1;
        end
        else
        begin
            weight_next = w_full[WEIGHT_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            weight_reg <= weight_next;
            status_reg <= ex_err_reg[T_BITS-1];
        end
    end

    assign out_valid = out_valid_reg;
    assign weight    = weight_reg;
    assign status    = status_reg;

endmodule
